FILE: rtl/modular_exponentiation_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core.
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`ifndef SYNTH
// Check that is switched off while reset is high.
`define MEC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that also holds during reset.
`define MEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MEC_ASSERT(lbl, clk, rst, prop, msg)
`define MEC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/mec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, the fixed prime and the controller state type.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int BASE_W       = 63;
  localparam int EXPONENT_W   = 63;
  localparam int RESULT_W     = 30;
  localparam int EXP_BITS_DEF = 63;

  // The modulus is a 30-bit prime.
  localparam logic [RESULT_W-1:0] PRIME_MOD = 30'd1000000007;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/mec_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand channel
// Carries one base and one exponent per request.
// ----------------------------------------------------------------------------
interface mec_in_if;
  logic                         valid;
  logic                         ready;
  logic [mec_pkg::BASE_W-1:0]     base_value;
  logic [mec_pkg::EXPONENT_W-1:0] exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

FILE: rtl/mec_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one modular power per request.
// ----------------------------------------------------------------------------
interface mec_out_if;
  logic                         valid;
  logic                         ready;
  logic [mec_pkg::RESULT_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

FILE: rtl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes base_value ^ exponent mod 1000000007 by right-to-left
// square-and-multiply with bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// Usage:
// The operands channel takes one request (base_value, exponent) when valid
// and ready are both high. Ready is high only while the core is idle.
// The base is first reduced modulo the prime, one base bit per cycle. Each
// exponent bit then takes one round, in which two bit-serial multipliers
// form the new square and the new accumulator side by side, scanning one
// bit of the square per cycle. The rounds stop after the highest set
// exponent bit, and a zero exponent skips them.
// The results channel is an output register. A finished result waits there
// while the receiver stalls, and the core already accepts and works on the
// next request; that one waits in its last state until the register frees.
// A synchronous reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core #(
  parameter int EXP_BITS = mec_pkg::EXP_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  mec_in_if.sink   operands,
  mec_out_if.source results
);
  import mec_pkg::*;

  localparam int RCNT_W = $clog2(BASE_W);
  localparam int MCNT_W = $clog2(RESULT_W);
  localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(BASE_W - 1);
  localparam logic [MCNT_W-1:0] MCNT_TOP  = MCNT_W'(RESULT_W - 1);
  localparam logic [RESULT_W+1:0] PRIME_W2 = {2'b00, PRIME_MOD};
  localparam logic [RESULT_W+1:0] PRIME_X2 = {1'b0, PRIME_MOD, 1'b0};

  // One step of an MSB-first modular multiply: (2r + (b ? a : 0)) mod P.
  // The sum is below 3P, so at most two subtractions bring it in range.
  function automatic logic [RESULT_W-1:0] mod_step(input logic [RESULT_W-1:0] r,
                                                    input logic b,
                                                    input logic [RESULT_W-1:0] a);
    logic [RESULT_W+1:0] t;
    logic [RESULT_W+1:0] u;
    t = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
    if (t >= PRIME_X2) begin
      u = t - PRIME_X2;
    end else if (t >= PRIME_W2) begin
      u = t - PRIME_W2;
    end else begin
      u = t;
    end
    return u[RESULT_W-1:0];
  endfunction

  state_t state;
  state_t state_next;

  logic [BASE_W-1:0]   breg;
  logic [EXP_BITS-1:0] exp_reg;
  logic [RESULT_W-1:0] sq;
  logic [RESULT_W-1:0] acc;
  logic [RESULT_W-1:0] mreg;
  logic [RESULT_W-1:0] r_sq;
  logic [RESULT_W-1:0] r_acc;
  logic [RCNT_W-1:0]   rcnt;
  logic [MCNT_W-1:0]   mcnt;
  logic                out_valid;
  logic [RESULT_W-1:0] out_result;

  logic                in_take;
  logic                out_free;
  logic                exp_last;
  logic [RESULT_W:0]   red_sum;
  logic [RESULT_W-1:0] red_next;
  logic [RESULT_W-1:0] sq_step;
  logic [RESULT_W-1:0] acc_step;

  // Handshake conditions.
  assign in_take  = operands.valid && operands.ready;
  assign out_free = !out_valid || results.ready;
  assign exp_last = (exp_reg >> 1) == '0;

  // Base reduction shifts one base bit into the remainder per cycle.
  always_comb begin
    red_sum = {sq, breg[BASE_W-1]};
    if (red_sum >= {1'b0, PRIME_MOD}) begin
      red_next = RESULT_W'(red_sum - {1'b0, PRIME_MOD});
    end else begin
      red_next = red_sum[RESULT_W-1:0];
    end
  end

  // Both multipliers scan the same bits of the square.
  assign sq_step  = mod_step(r_sq, mreg[RESULT_W-1], sq);
  assign acc_step = mod_step(r_acc, mreg[RESULT_W-1], acc);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (rcnt == RCNT_LAST) state_next = (exp_reg == '0) ? ST_FINISH : ST_MULT;
      end
      ST_MULT: begin
        if (mcnt == '0 && exp_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    operands.ready = (state == ST_IDLE);
    results.valid  = out_valid;
    results.result = out_result;
  end

  // State register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          breg    <= operands.base_value;
          exp_reg <= operands.exponent[EXP_BITS-1:0];
          sq      <= '0;
          acc     <= RESULT_W'(1);
          rcnt    <= '0;
        end
      end
      ST_REDUCE: begin
        breg <= breg << 1;
        sq   <= red_next;
        rcnt <= rcnt + 1'b1;
        mreg  <= red_next;
        r_sq  <= '0;
        r_acc <= '0;
        mcnt  <= MCNT_TOP;
      end
      ST_MULT: begin
        if (mcnt == '0) begin
          sq <= sq_step;
          if (exp_reg[0]) acc <= acc_step;
          exp_reg <= exp_reg >> 1;
          mreg    <= sq_step;
          r_sq    <= '0;
          r_acc   <= '0;
          mcnt    <= MCNT_TOP;
        end else begin
          mreg  <= mreg << 1;
          r_sq  <= sq_step;
          r_acc <= acc_step;
          mcnt  <= mcnt - 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) out_result <= acc;
      end
      default: begin
      end
    endcase
  end

  // Invariants of the multiply rounds and the result handoff.
  `MEC_ASSERT(a_sq_reduced, clk, rst, (state == ST_MULT) |-> (sq < PRIME_MOD), "square not reduced")
  `MEC_ASSERT(a_acc_reduced, clk, rst, (state == ST_MULT) |-> (acc < PRIME_MOD), "accumulator not reduced")
  `MEC_ASSERT(a_exp_live, clk, rst, (state == ST_MULT) |-> (exp_reg != '0), "round with empty exponent")
  `MEC_ASSERT(a_out_from_finish, clk, rst, $rose(out_valid) |-> $past(state == ST_FINISH), "result not from finish")
  `MEC_ASSERT(a_result_reduced, clk, rst, out_valid |-> (out_result < PRIME_MOD), "result out of range")

endmodule
